/* sv/oas_pkg.sv */
// Shared types, widths and constants for the obstacle avoidance steering core.
`default_nettype none

package oas_pkg;

   // Sensor distance width, Q12.4
   localparam int DIST_BITS = 16;
   // Configuration register widths
   localparam int CFG_BITS  = 16;
   localparam int RATE_BITS = 10;
   localparam int FTIME_BITS = 16;
   localparam int CSR_IDX_BITS = 3;

   // Nearest tracker holds either a sensor value or sensor_range
   localparam int NEAR_BITS = (DIST_BITS > CFG_BITS) ? DIST_BITS : CFG_BITS;
   // Release compare spans a distance and threshold + margin
   localparam int CLR_BITS = (DIST_BITS > CFG_BITS + 1) ? DIST_BITS : CFG_BITS + 1;
   // Sum of three distances
   localparam int SUM_BITS = DIST_BITS + 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SENSOR_RANGE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AVOID_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLEAR_MARGIN    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TURN_RATE   = 3'd3;

   // Register reset values
   localparam logic [CFG_BITS-1:0]  RST_SENSOR_RANGE    = 16'd1600;
   localparam logic [CFG_BITS-1:0]  RST_AVOID_THRESHOLD = 16'd640;
   localparam logic [CFG_BITS-1:0]  RST_CLEAR_MARGIN    = 16'd320;
   localparam logic [RATE_BITS-1:0] RST_MAX_TURN_RATE   = 10'd360;

   typedef enum logic [1:0] {
      SIDE_NONE = 2'd0,
      SIDE_POS  = 2'd1,
      SIDE_NEG  = 2'd2
   } side_type;

   // Strength, Q0.16 plus the full-scale bit
   localparam int STR_FRAC = 16;
   localparam int STR_BITS = STR_FRAC + 1;
   localparam logic [STR_BITS-1:0] STR_FULL = STR_BITS'(1) << STR_FRAC;
   localparam int DIV_CNT_BITS = $clog2(STR_FRAC + 1);

   // Serial multiplier, three passes: s*rate, *frame_time, *deg-to-rad
   localparam int MCAND_BITS  = 19;
   localparam logic [MCAND_BITS-1:0] DEG_TO_RAD_Q24 = 19'd292818;
   localparam int M1_BITS     = STR_BITS + RATE_BITS;
   localparam int M2_BITS     = M1_BITS + FTIME_BITS;
   localparam int MPLIER_BITS = M2_BITS;
   localparam int PROD_BITS   = MPLIER_BITS + MCAND_BITS;
   localparam int M1_LSB      = MPLIER_BITS - STR_BITS;
   localparam int M2_LSB      = MPLIER_BITS - M1_BITS;
   localparam int STEP_BITS   = $clog2(MPLIER_BITS + 1);
   localparam logic [STEP_BITS-1:0] STEPS_1 = STEP_BITS'(STR_BITS);
   localparam logic [STEP_BITS-1:0] STEPS_2 = STEP_BITS'(M1_BITS);
   localparam logic [STEP_BITS-1:0] STEPS_3 = STEP_BITS'(M2_BITS);

   // Turn scaling: >> 40 with half-up rounding, saturate to 21 bits
   localparam int MAG_LSB  = 40;
   localparam int TURN_BITS = 22;
   localparam int MAG_BITS = PROD_BITS - MAG_LSB;
   localparam logic [MAG_BITS:0] TURN_MAX = (MAG_BITS + 1)'((1 << (TURN_BITS - 1)) - 1);

   typedef struct packed {
      logic                start;
      logic [CFG_BITS-1:0] rem;
      logic [CFG_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [STR_FRAC-1:0] quo;
   } div_sts_type;

   typedef struct packed {
      logic                   start;
      logic [MCAND_BITS-1:0]  mcand;
      logic [MPLIER_BITS-1:0] mplier;
      logic [STEP_BITS-1:0]   steps;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] prod;
   } mul_sts_type;

endpackage

`default_nettype wire

/* sv/oas_req_if.sv */
// Request channel: one frame of sensor distances with valid/ready.
`default_nettype none

interface oas_req_if import oas_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] dist_left_outer;
   logic [DIST_BITS-1:0] dist_left_mid;
   logic [DIST_BITS-1:0] dist_left_front;
   logic [DIST_BITS-1:0] dist_center;
   logic [DIST_BITS-1:0] dist_right_front;
   logic [DIST_BITS-1:0] dist_right_mid;
   logic [DIST_BITS-1:0] dist_right_outer;
   logic [FTIME_BITS-1:0] frame_time;
   logic                 in_recovery;

   modport source (
      output valid, dist_left_outer, dist_left_mid, dist_left_front, dist_center,
             dist_right_front, dist_right_mid, dist_right_outer, frame_time, in_recovery,
      input  ready
   );
   modport sink (
      input  valid, dist_left_outer, dist_left_mid, dist_left_front, dist_center,
             dist_right_front, dist_right_mid, dist_right_outer, frame_time, in_recovery,
      output ready
   );
endinterface

`default_nettype wire

/* sv/oas_rsp_if.sv */
// Response channel: steering result with valid/ready.
`default_nettype none

interface oas_rsp_if import oas_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic signed [TURN_BITS-1:0] turn_angle;
   logic [STR_BITS-1:0]         strength;
   logic [1:0]                  side;

   modport source (output valid, turn_angle, strength, side, input ready);
   modport sink   (input valid, turn_angle, strength, side, output ready);
endinterface

`default_nettype wire

/* sv/oas_div.sv */
// Bit-serial restoring divider producing the 16 fraction bits of strength.
`default_nettype none

module oas_div import oas_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [CFG_BITS-1:0]     rem_ff;
   logic [CFG_BITS-1:0]     dvs_ff;
   logic [STR_FRAC-1:0]     quo_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;

   logic [CFG_BITS:0] rem2;
   logic [CFG_BITS:0] diff;
   logic              ge;
   logic [CFG_BITS-1:0] rem_in;

   // remainder stays below the divisor, so one compare-subtract per bit
   always_comb begin
      rem2   = {rem_ff, 1'b0};
      diff   = rem2 - {1'b0, dvs_ff};
      ge     = (rem2 >= {1'b0, dvs_ff});
      rem_in = ge ? diff[CFG_BITS-1:0] : rem2[CFG_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses for one cycle after the last quotient bit
         done_ff <= !cmd.start && busy_ff && (cnt_ff == DIV_CNT_BITS'(1));
         if (cmd.start) begin
            rem_ff  <= cmd.rem;
            dvs_ff  <= cmd.divisor;
            quo_ff  <= '0;
            cnt_ff  <= DIV_CNT_BITS'(STR_FRAC);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[STR_FRAC-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(1))
               busy_ff <= 1'b0;
         end
      end
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;

endmodule

`default_nettype wire

/* sv/oas_mul.sv */
// Serial shift-add multiplier: parallel multiplicand, multiplier bits LSB first.
`default_nettype none

module oas_mul import oas_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  mul_cmd_type cmd,
   output mul_sts_type sts
);

   logic [MCAND_BITS-1:0]  mc_ff;
   logic [MCAND_BITS-1:0]  hi_ff;
   logic [MPLIER_BITS-1:0] lo_ff;
   logic [STEP_BITS-1:0]   cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;

   logic [MCAND_BITS:0] sum;

   // partial sum stays one bit over the multiplicand; its LSB drops into lo
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mc_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses for one cycle after the last step
         done_ff <= !cmd.start && busy_ff && (cnt_ff == STEP_BITS'(1));
         if (cmd.start) begin
            mc_ff   <= cmd.mcand;
            hi_ff   <= '0;
            lo_ff   <= cmd.mplier;
            cnt_ff  <= cmd.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            hi_ff  <= sum[MCAND_BITS:1];
            lo_ff  <= {sum[0], lo_ff[MPLIER_BITS-1:1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_BITS'(1))
               busy_ff <= 1'b0;
         end
      end
   end

   assign sts.done = done_ff;
   assign sts.prod = {hi_ff, lo_ff};

endmodule

`default_nettype wire

/* sv/obstacle_avoidance_steering_core.sv */
// Obstacle avoidance steering core: side latch, strength divide, serial turn scaling.
`default_nettype none

// Channel     Dir   Transfer when            Carries
// req_ch      in    valid && ready           seven distances, frame_time, in_recovery
// rsp_ch      out   valid && ready           turn_angle, strength, side
// csr_*       in    csr_write_en high        index 0..3 registers, others ignored
//
// A frame that needs no avoidance goes from decide straight to output with no
// arithmetic pass; its result is registered as the core returns to idle for the next frame.
// An avoiding frame runs 16 steps of the bit-serial divider (skipped when the
// nearest reading is zero) and 17 + 27 + 43 steps of the serial multiplier for
// the three scaling passes, between the decide and output states.
// Reset is synchronous; no clearing pass. The result sits in an output register,
// so the next frame is taken while a result waits; a stalled rsp_ch holds only
// the frame after that, in its last state.

module obstacle_avoidance_steering_core import oas_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   oas_req_if.sink                      req_ch,
   oas_rsp_if.source                    rsp_ch,
   input  wire logic                    csr_write_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]     csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      DG_LEFT, DG_CENTER, DG_RIGHT
   } danger_type;

   // configuration
   logic [CFG_BITS-1:0]  range_ff;
   logic [CFG_BITS-1:0]  thr_ff;
   logic [CFG_BITS-1:0]  margin_ff;
   logic [RATE_BITS-1:0] rate_ff;

   // captured frame
   logic [DIST_BITS-1:0]  d_lo_ff, d_lm_ff, d_lf_ff, d_c_ff, d_rf_ff, d_rm_ff, d_ro_ff;
   logic [FTIME_BITS-1:0] ftime_ff;
   logic                  recov_ff;

   state_type               state_ff;
   side_type                side_ff;
   logic [STR_BITS-1:0]     str_ff;
   logic [TURN_BITS-1:0]    turn_ff;
   div_cmd_type             div_cmd_ff;
   mul_cmd_type             mul_cmd_ff;
   div_sts_type             div_sts;
   mul_sts_type             mul_sts;

   logic                    rsp_valid_ff;
   logic [TURN_BITS-1:0]    rsp_turn_ff;
   logic [STR_BITS-1:0]     rsp_str_ff;
   side_type                rsp_side_ff;

   // decision terms
   logic [NEAR_BITS-1:0] nearest;
   danger_type           danger;
   logic [CLR_BITS-1:0]  clear_lvl;
   side_type             held_side;
   side_type             side_in;
   logic                 avoid;
   logic [SUM_BITS-1:0]  lsum, rsum;

   // turn terms
   logic [MAG_BITS:0]    mag_sum;
   logic [MAG_BITS-1:0]  mag;
   logic [TURN_BITS-1:0] turn_in;

   //------------------------------------------------------------------
   // configuration writes
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= RST_SENSOR_RANGE;
         thr_ff    <= RST_AVOID_THRESHOLD;
         margin_ff <= RST_CLEAR_MARGIN;
         rate_ff   <= RST_MAX_TURN_RATE;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SENSOR_RANGE:    range_ff  <= csr_data;
            CSR_AVOID_THRESHOLD: thr_ff    <= csr_data;
            CSR_CLEAR_MARGIN:    margin_ff <= csr_data;
            CSR_MAX_TURN_RATE:   rate_ff   <= csr_data[RATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------
   // nearest front sensor, latch release, side choice
   //------------------------------------------------------------------
   always_comb begin
      // strict less-than keeps ties on the earlier sensor
      nearest = NEAR_BITS'(range_ff);
      danger  = DG_CENTER;
      if (NEAR_BITS'(d_lf_ff) < nearest) begin
         nearest = NEAR_BITS'(d_lf_ff);
         danger  = DG_LEFT;
      end
      if (NEAR_BITS'(d_c_ff) < nearest) begin
         nearest = NEAR_BITS'(d_c_ff);
         danger  = DG_CENTER;
      end
      if (NEAR_BITS'(d_rf_ff) < nearest) begin
         nearest = NEAR_BITS'(d_rf_ff);
         danger  = DG_RIGHT;
      end

      clear_lvl = CLR_BITS'(thr_ff) + CLR_BITS'(margin_ff);

      // release runs every frame, recovery or not
      case (side_ff)
         SIDE_POS: begin
            if (CLR_BITS'(d_c_ff) > clear_lvl && CLR_BITS'(d_lf_ff) > clear_lvl)
               held_side = SIDE_NONE;
            else
               held_side = SIDE_POS;
         end
         SIDE_NEG: begin
            if (CLR_BITS'(d_c_ff) > clear_lvl && CLR_BITS'(d_rf_ff) > clear_lvl)
               held_side = SIDE_NONE;
            else
               held_side = SIDE_NEG;
         end
         default: held_side = SIDE_NONE;
      endcase

      avoid = (nearest <= NEAR_BITS'(thr_ff)) && !recov_ff;

      lsum = SUM_BITS'(d_lo_ff) + SUM_BITS'(d_lm_ff) + SUM_BITS'(d_lf_ff);
      rsum = SUM_BITS'(d_rf_ff) + SUM_BITS'(d_rm_ff) + SUM_BITS'(d_ro_ff);

      side_in = held_side;
      if (avoid && held_side == SIDE_NONE) begin
         case (danger)
            DG_LEFT:  side_in = SIDE_POS;
            DG_RIGHT: side_in = SIDE_NEG;
            default:  side_in = (lsum <= rsum) ? SIDE_POS : SIDE_NEG;
         endcase
      end
   end

   //------------------------------------------------------------------
   // final scaling: round half up at bit 40, saturate, apply sign
   //------------------------------------------------------------------
   always_comb begin
      mag_sum = {1'b0, mul_sts.prod[PROD_BITS-1:MAG_LSB]}
              + (MAG_BITS + 1)'(mul_sts.prod[MAG_LSB-1]);
      if (mag_sum > TURN_MAX)
         mag = TURN_MAX[MAG_BITS-1:0];
      else
         mag = mag_sum[MAG_BITS-1:0];
      if (side_ff == SIDE_POS)
         turn_in = TURN_BITS'(mag);
      else
         turn_in = TURN_BITS'(0) - TURN_BITS'(mag);
   end

   //------------------------------------------------------------------
   // arithmetic units
   //------------------------------------------------------------------
   oas_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd_ff),
      .sts   (div_sts)
   );

   oas_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd_ff),
      .sts   (mul_sts)
   );

   //------------------------------------------------------------------
   // sequencer and output register
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         side_ff          <= SIDE_NONE;
         rsp_valid_ff     <= 1'b0;
         div_cmd_ff.start <= 1'b0;
         mul_cmd_ff.start <= 1'b0;
      end else begin
         // one-cycle start pulses for the arithmetic units
         div_cmd_ff.start <= (state_ff == S_DECIDE) && avoid && (nearest != '0);
         mul_cmd_ff.start <= ((state_ff == S_DECIDE) && avoid && (nearest == '0))
                          || ((state_ff == S_DIV) && div_sts.done)
                          || ((state_ff == S_MUL1 || state_ff == S_MUL2) && mul_sts.done);
         // in S_OUT a draining register is refilled in the same cycle
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  d_lo_ff  <= req_ch.dist_left_outer;
                  d_lm_ff  <= req_ch.dist_left_mid;
                  d_lf_ff  <= req_ch.dist_left_front;
                  d_c_ff   <= req_ch.dist_center;
                  d_rf_ff  <= req_ch.dist_right_front;
                  d_rm_ff  <= req_ch.dist_right_mid;
                  d_ro_ff  <= req_ch.dist_right_outer;
                  ftime_ff <= req_ch.frame_time;
                  recov_ff <= req_ch.in_recovery;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               side_ff <= side_in;
               if (!avoid) begin
                  str_ff   <= '0;
                  turn_ff  <= '0;
                  state_ff <= S_OUT;
               end else if (nearest == '0) begin
                  // zero reading, also the only way in with a zero threshold
                  str_ff            <= STR_FULL;
                  mul_cmd_ff.mcand  <= MCAND_BITS'(rate_ff);
                  mul_cmd_ff.mplier <= MPLIER_BITS'(STR_FULL);
                  mul_cmd_ff.steps  <= STEPS_1;
                  state_ff          <= S_MUL1;
               end else begin
                  div_cmd_ff.rem     <= thr_ff - nearest[CFG_BITS-1:0];
                  div_cmd_ff.divisor <= thr_ff;
                  state_ff           <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_sts.done) begin
                  str_ff            <= STR_BITS'(div_sts.quo);
                  mul_cmd_ff.mcand  <= MCAND_BITS'(rate_ff);
                  mul_cmd_ff.mplier <= MPLIER_BITS'(div_sts.quo);
                  mul_cmd_ff.steps  <= STEPS_1;
                  state_ff          <= S_MUL1;
               end
            end
            S_MUL1: begin
               if (mul_sts.done) begin
                  mul_cmd_ff.mcand  <= MCAND_BITS'(ftime_ff);
                  mul_cmd_ff.mplier <= MPLIER_BITS'(mul_sts.prod[M1_LSB +: M1_BITS]);
                  mul_cmd_ff.steps  <= STEPS_2;
                  state_ff          <= S_MUL2;
               end
            end
            S_MUL2: begin
               if (mul_sts.done) begin
                  mul_cmd_ff.mcand  <= DEG_TO_RAD_Q24;
                  mul_cmd_ff.mplier <= mul_sts.prod[M2_LSB +: M2_BITS];
                  mul_cmd_ff.steps  <= STEPS_3;
                  state_ff          <= S_MUL3;
               end
            end
            S_MUL3: begin
               if (mul_sts.done) begin
                  turn_ff  <= turn_in;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_turn_ff  <= turn_ff;
                  rsp_str_ff   <= str_ff;
                  rsp_side_ff  <= side_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.turn_angle = rsp_turn_ff;
   assign rsp_ch.strength   = rsp_str_ff;
   assign rsp_ch.side       = rsp_side_ff;

endmodule

`default_nettype wire

/* sv/oas_checker.sv */
// Port-level assertions for the steering core and their bind.
`default_nettype none

module oas_checker import oas_pkg::*; (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic signed [TURN_BITS-1:0] turn_angle,
   input wire logic [STR_BITS-1:0]         strength,
   input wire logic [1:0]                  side
);

   // no strength means no turn
   a_zero_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && strength == '0 |-> turn_angle == '0)
      else $error("turn without strength");

   // avoiding always leaves a side latched
   a_side_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && strength != '0 |-> side == SIDE_POS || side == SIDE_NEG)
      else $error("strength with no side");

   // turn sign follows the side
   a_turn_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (side != SIDE_POS || !turn_angle[TURN_BITS-1])
                 && (side != SIDE_NEG || turn_angle[TURN_BITS-1] || turn_angle == '0))
      else $error("turn sign disagrees with side");

   // strength never exceeds full scale
   a_str_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !strength[STR_BITS-1] || strength[STR_BITS-2:0] == '0)
      else $error("strength above full scale");

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(strength) && $stable(turn_angle))
      else $error("stalled result changed");

endmodule

bind obstacle_avoidance_steering_core oas_checker u_oas_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .turn_angle (rsp_ch.turn_angle),
   .strength   (rsp_ch.strength),
   .side       (rsp_ch.side)
);

`default_nettype wire
